/* rtl/core/ewa_pkg.sv */
package ewa_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 8;
    localparam int POS_W    = 12;
    localparam int WLEN_W   = 6;
    localparam int QUOT_W   = 8;

    // defaults for the top level parameters
    localparam int DEF_MAX_POINTS = 4096;
    localparam int DEF_MAX_WINDOW = 32;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SETUP  = 9'b000000010,
        ST_CENTRE = 9'b000000100,
        ST_PAIR   = 9'b000001000,
        ST_EXTRA  = 9'b000010000,
        ST_DRAIN  = 9'b000100000,
        ST_DIVGO  = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

endpackage

/* rtl/core/ewa_mem.sv */
module ewa_mem #(
    parameter int DEPTH  = 33,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/ewa_div.sv */
module ewa_div import ewa_pkg::*; #(
    parameter int SUM_W = 14,
    parameter int CNT_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [QUOT_W-1:0] quotient
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [CNT_W-1:0]  dvs_reg,   dvs_next;
    logic [QUOT_W-1:0] low_reg,   low_next;
    logic [QUOT_W-1:0] quot_reg,  quot_next;
    logic [CNT_W:0]    trial;

    // one restoring step per cycle; the quotient is known to fit in QUOT_W bits
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, low_reg[QUOT_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = CNT_W'(dividend >> QUOT_W);
            low_next  = dividend[QUOT_W-1:0];
            dvs_next  = divisor;
        end else if (busy_reg) begin
            low_next = {low_reg[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = CNT_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end else begin
                rem_next  = CNT_W'(trial);
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* rtl/core/edge_aware_window_average.sv */
// an averaged output starts once the sample h = window/2 places later is taken and
// reads the centre and the pairs in range, at most h of them, before the divide;
// a new sample request is taken only while the sequencer is idle, so not while an output
// is still being worked on; a window below 2 passes the sample through; the single read port
// of the sample store (two reads per pair) and the 8-step divider set the pace
// reset: synchronous, active low; counters cleared, window register set to 1
module edge_aware_window_average import ewa_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WLEN_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                s_end_of_record,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_smoothed,
    output logic [POS_W-1:0]    m_position,
    output logic                m_record_done
);

    localparam int WD  = (MAX_WINDOW / 2) * 2 + 1;
    localparam int AW  = $clog2(WD);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int DW  = $clog2(MAX_WINDOW / 2 + 2);
    localparam int WW  = $clog2(MAX_WINDOW + 1);
    localparam int XW  = ((PW > DW) ? PW : DW) + 1;
    localparam int SW  = $clog2(((1 << SAMPLE_W) - 1) * WD + 1);
    localparam int CNW = $clog2(WD + 1);

    state_t            state_reg,    state_next;
    logic [WLEN_W-1:0] wl_reg,       wl_next;
    logic [WW-1:0]     act_reg,      act_next;
    logic [PW-1:0]     recv_reg,     recv_next;
    logic [PW-1:0]     emit_reg,     emit_next;
    logic [PW-1:0]     pos_reg,      pos_next;
    logic [PW-1:0]     cur_reg,      cur_next;
    logic              last_reg,     last_next;
    logic [AW-1:0]     pslot_reg,    pslot_next;
    logic [AW-1:0]     nslot_reg,    nslot_next;
    logic [AW-1:0]     c_reg,        c_next;
    logic [AW-1:0]     lo_reg,       lo_next;
    logic [AW-1:0]     hi_reg,       hi_next;
    logic [DW-1:0]     d_reg,        d_next;
    logic              phase_reg,    phase_next;
    logic              pend_reg,     pend_next;
    logic [SW-1:0]     sum_reg,      sum_next;
    logic [CNW-1:0]    cnt_reg,      cnt_next;
    logic [SAMPLE_W-1:0] res_reg,    res_next;
    logic              m_valid_reg,  m_valid_next;
    logic [SAMPLE_W-1:0] m_smoothed_reg, m_smoothed_next;
    logic [POS_W-1:0]  m_position_reg,   m_position_next;
    logic              m_done_reg,       m_done_next;

    logic              in_req;
    logic              first;
    logic [WW-1:0]     win_sat;
    logic [WW-1:0]     win_in;
    logic [DW-1:0]     h_in;
    logic [DW-1:0]     h_cur;
    logic [AW-1:0]     slot_in;
    logic              last_in;
    logic [PW-1:0]     emit_base;
    logic [AW:0]       delta;
    logic [AW:0]       c_plus_h;
    logic [SW-1:0]     sum_acc;
    logic              pair_ok;
    logic              more;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    // circular slot stepping
    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == AW'(WD - 1)) ? '0 : AW'(s + 1'b1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        return (s == '0) ? AW'(WD - 1) : AW'(s - 1'b1);
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_req    = s_valid && s_ready;

    // request decode for a new sample
    always_comb begin
        first     = (recv_reg == '0);
        win_sat   = (int'(wl_reg) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(wl_reg);
        win_in    = first ? win_sat : act_reg;
        h_in      = DW'(win_in >> 1);
        h_cur     = DW'(act_reg >> 1);
        slot_in   = first ? '0 : nslot_reg;
        last_in   = s_end_of_record || (recv_reg == PW'(MAX_POINTS - 1));
        emit_base = first ? '0 : emit_reg;
    end

    // centre slot offset, slot of the odd-window extra term, running sum and pair range check
    always_comb begin
        delta    = (AW + 1)'(pos_reg - cur_reg);
        c_plus_h = (AW + 1)'(c_reg) + (AW + 1)'(h_cur);
        if (c_plus_h >= (AW + 1)'(WD)) begin
            c_plus_h = c_plus_h - (AW + 1)'(WD);
        end
        sum_acc = sum_reg + (pend_reg ? SW'(rd_data) : SW'(0));
        pair_ok = (d_reg <= h_cur) && (XW'(d_reg) <= XW'(cur_reg))
                  && (XW'(cur_reg) + XW'(d_reg) <= XW'(pos_reg));
        more    = last_reg && (cur_reg != pos_reg);
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        wl_next         = wl_reg;
        act_next        = act_reg;
        recv_next       = recv_reg;
        emit_next       = emit_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        pslot_next      = pslot_reg;
        nslot_next      = nslot_reg;
        c_next          = c_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        d_next          = d_reg;
        phase_next      = phase_reg;
        pend_next       = 1'b0;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_smoothed_next = m_smoothed_reg;
        m_position_next = m_position_reg;
        m_done_next     = m_done_reg;
        rd_en           = 1'b0;
        rd_addr         = c_reg;
        div_start       = 1'b0;

        if (cfg_valid && cfg_ready) begin
            wl_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    act_next   = win_in;
                    pos_next   = recv_reg;
                    last_next  = last_in;
                    pslot_next = slot_in;
                    nslot_next = slot_inc(slot_in);
                    emit_next  = emit_base;
                    recv_next  = last_in ? '0 : PW'(recv_reg + 1'b1);
                    if (win_in < WW'(2)) begin
                        res_next   = s_sample;
                        cur_next   = recv_reg;
                        state_next = ST_EMIT;
                    end else if (last_in) begin
                        cur_next   = emit_base;
                        state_next = ST_SETUP;
                    end else if (XW'(recv_reg) >= XW'(h_in)) begin
                        cur_next   = PW'(XW'(recv_reg) - XW'(h_in));
                        emit_next  = PW'(XW'(recv_reg) - XW'(h_in) + 1'b1);
                        state_next = ST_SETUP;
                    end
                    if (last_in) begin
                        emit_next = '0;
                    end
                end
            end
            ST_SETUP: begin
                if ({1'b0, pslot_reg} >= delta) begin
                    c_next = AW'({1'b0, pslot_reg} - delta);
                end else begin
                    c_next = AW'({1'b0, pslot_reg} + (AW + 1)'(WD) - delta);
                end
                state_next = ST_CENTRE;
            end
            ST_CENTRE: begin
                rd_en      = 1'b1;
                rd_addr    = c_reg;
                pend_next  = 1'b1;
                sum_next   = '0;
                cnt_next   = CNW'(1);
                lo_next    = slot_dec(c_reg);
                hi_next    = slot_inc(c_reg);
                d_next     = DW'(1);
                phase_next = 1'b0;
                state_next = ST_PAIR;
            end
            ST_PAIR: begin
                sum_next = sum_acc;
                if (!phase_reg) begin
                    if (pair_ok) begin
                        rd_en      = 1'b1;
                        rd_addr    = lo_reg;
                        pend_next  = 1'b1;
                        phase_next = 1'b1;
                    end else begin
                        state_next = ST_EXTRA;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = hi_reg;
                    pend_next  = 1'b1;
                    cnt_next   = CNW'(cnt_reg + 2'd2);
                    d_next     = DW'(d_reg + 1'b1);
                    lo_next    = slot_dec(lo_reg);
                    hi_next    = slot_inc(hi_reg);
                    phase_next = 1'b0;
                end
            end
            ST_EXTRA: begin
                sum_next = sum_acc;
                if (act_reg[0] && (XW'(cur_reg) + XW'(h_cur) <= XW'(pos_reg))) begin
                    rd_en     = 1'b1;
                    rd_addr   = AW'(c_plus_h);
                    pend_next = 1'b1;
                    cnt_next  = CNW'(cnt_reg + 1'b1);
                end
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                sum_next   = sum_acc;
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = div_quot;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_smoothed_next = res_reg;
                    m_position_next = POS_W'(cur_reg);
                    m_done_next     = last_reg && (cur_reg == pos_reg);
                    if (more) begin
                        cur_next   = PW'(cur_reg + 1'b1);
                        state_next = ST_SETUP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wl_reg      <= WLEN_W'(1);
            act_reg     <= WW'(1);
            recv_reg    <= '0;
            emit_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wl_reg      <= wl_next;
            act_reg     <= act_next;
            recv_reg    <= recv_next;
            emit_reg    <= emit_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        pslot_reg      <= pslot_next;
        nslot_reg      <= nslot_next;
        c_reg          <= c_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        d_reg          <= d_next;
        phase_reg      <= phase_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        res_reg        <= res_next;
        m_smoothed_reg <= m_smoothed_next;
        m_position_reg <= m_position_next;
        m_done_reg     <= m_done_next;
    end

    // sample store, one slot per position modulo its depth
    ewa_mem #(
        .DEPTH  (WD),
        .ADDR_W (AW),
        .DATA_W (SAMPLE_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (in_req),
        .wr_addr (slot_in),
        .wr_data (s_sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // divider for sum over count
    ewa_div #(
        .SUM_W (SW),
        .CNT_W (CNW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_valid       = m_valid_reg;
    assign m_smoothed    = m_smoothed_reg;
    assign m_position    = m_position_reg;
    assign m_record_done = m_done_reg;

endmodule
